// File: rtl/bounce_easing_curve_core_assert.svh
// assertion macros shared by the bounce easing curve rtl
`ifndef BOUNCE_EASING_CURVE_CORE_ASSERT_SVH
`define BOUNCE_EASING_CURVE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BEC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BEC_ASSERT_NEVER(label, clk, rst, cond, msg) \
   `BEC_ASSERT(label, clk, rst, !(cond), msg)
`else
`define BEC_ASSERT(label, clk, rst, prop, msg)
`define BEC_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: rtl/bec_pkg.sv
// shared types and constants for the bounce easing curve core
package bec_pkg;

   localparam int VALUE_BITS_DEFAULT    = 16;
   localparam int TIME_BITS_DEFAULT     = 16;
   localparam int FRACTION_BITS_DEFAULT = 16;

   localparam int CSR_INDEX_BITS = 2;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_START_VALUE  = 2'd0,
      CSR_TARGET_VALUE = 2'd1,
      CSR_ANIM_LENGTH  = 2'd2,
      CSR_EASE_IN_MODE = 2'd3
   } csr_index_type;

   // per-stage control that travels with each item
   typedef struct packed {
      logic valid;
      logic done;
   } stage_ctl_type;

endpackage

// File: rtl/bec_divider.sv
// pipelined restoring divider: one quotient bit per stage, tags items past the end
`include "bounce_easing_curve_core_assert.svh"

module bec_divider #(
   parameter int TIME_BITS     = bec_pkg::TIME_BITS_DEFAULT,
   parameter int FRACTION_BITS = bec_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [TIME_BITS-1:0]     in_elapsed,
   input  logic [TIME_BITS-1:0]     divisor,
   output bec_pkg::stage_ctl_type   out_ctl,
   input  logic                     out_ready,
   output logic [FRACTION_BITS-1:0] out_quotient
);
   import bec_pkg::*;

   localparam int STAGES = FRACTION_BITS;

   stage_ctl_type            ctl_ff [STAGES];
   logic [TIME_BITS-1:0]     rem_ff [STAGES];
   logic [FRACTION_BITS-1:0] quo_ff [STAGES];
   logic [STAGES:0]          move;
   logic [STAGES-1:0]        stage_valid;

   assign move[STAGES] = out_ready;

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      stage_ctl_type            ctl_prev;
      logic [TIME_BITS-1:0]     rem_prev;
      logic [FRACTION_BITS-1:0] quo_prev;
      logic [TIME_BITS:0]       rem_dbl;
      logic [TIME_BITS:0]       rem_diff;
      logic                     take;
      logic [TIME_BITS-1:0]     rem_in;
      logic [FRACTION_BITS-1:0] quo_in;

      if (s == 0) begin : g_head
         // elapsed at or past the length (also a zero length) skips the fraction
         assign ctl_prev = '{valid: in_valid, done: (in_elapsed >= divisor)};
         assign rem_prev = in_elapsed;
         assign quo_prev = '0;
      end else begin : g_body
         assign ctl_prev = ctl_ff[s-1];
         assign rem_prev = rem_ff[s-1];
         assign quo_prev = quo_ff[s-1];
      end

      assign move[s]        = !ctl_ff[s].valid || move[s+1];
      assign stage_valid[s] = ctl_ff[s].valid;

      assign rem_dbl  = {rem_prev, 1'b0};
      assign rem_diff = rem_dbl - {1'b0, divisor};
      assign take     = (rem_dbl >= {1'b0, divisor});
      assign rem_in   = take ? rem_diff[TIME_BITS-1:0] : rem_dbl[TIME_BITS-1:0];
      assign quo_in   = {quo_prev[FRACTION_BITS-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[s] <= '0;
         end else if (move[s]) begin
            ctl_ff[s] <= ctl_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (move[s]) begin
            rem_ff[s] <= rem_in;
            quo_ff[s] <= quo_in;
         end
      end
   end

   assign in_ready     = move[0];
   assign out_ctl      = ctl_ff[STAGES-1];
   assign out_quotient = quo_ff[STAGES-1];

   `BEC_ASSERT(a_blocked_only_when_full, clock, reset, !in_ready |-> &stage_valid,
      "divider refuses input with a free stage")
   `BEC_ASSERT(a_zero_length_is_done, clock, reset,
      in_valid && in_ready && divisor == '0 |=> ctl_ff[0].done,
      "zero length item not tagged as done")

   for (genvar s = 0; s < STAGES; s++) begin : g_check
      `BEC_ASSERT(a_remainder_below_divisor, clock, reset,
         ctl_ff[s].valid && !ctl_ff[s].done |-> rem_ff[s] < divisor,
         "partial remainder reached the divisor")
   end

endmodule

// File: rtl/bounce_easing_curve_core.sv
// bounce easing curve core: csr block, divider, curve and blend pipeline
//
// Usage:
//   req channel carries one elapsed time per transfer (req_valid / req_stall);
//   rsp channel returns one eased value and an at_end flag per request, in order.
//   csr channel (csr_valid / csr_ready, csr_ready always high) writes start value,
//   target value, animation length and ease-in mode; write it only while idle.
// Timing:
//   from request transfer to rsp_valid an item passes one divider stage per
//   fraction bit, then curve segment, square, offset and round, scale, blend.
//   throughput is one item per cycle while rsp_stall is low; every stage takes
//   a new item each cycle unless the stage ahead of it is full and stalled.
// Reset:
//   clears all valid bits; registers return to start 0, target 0, length 1,
//   ease-out mode.
// Stall:
//   a stalled rsp holds its value; items behind it close up empty stages and
//   req_stall rises only once every stage holds an item.
`include "bounce_easing_curve_core_assert.svh"

module bounce_easing_curve_core #(
   parameter int VALUE_BITS    = bec_pkg::VALUE_BITS_DEFAULT,
   parameter int TIME_BITS     = bec_pkg::TIME_BITS_DEFAULT,
   parameter int FRACTION_BITS = bec_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [TIME_BITS-1:0]                 req_elapsed_time,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [VALUE_BITS-1:0]         rsp_eased_value,
   output logic                                 rsp_at_end,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bec_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [((VALUE_BITS > TIME_BITS) ? VALUE_BITS : TIME_BITS)-1:0] csr_data
);
   import bec_pkg::*;

   localparam int PIPE_STAGES = 5;
   localparam int ONE_W  = FRACTION_BITS + 1;
   localparam int T11_W  = FRACTION_BITS + 5;
   localparam int DS_W   = FRACTION_BITS + 7;
   localparam int D_W    = FRACTION_BITS + 4;
   localparam int SQ_W   = 2 * D_W;
   localparam int NUM_W  = 2 * FRACTION_BITS + 9;
   localparam int PROD_W = VALUE_BITS + FRACTION_BITS + 1;

   localparam logic [ONE_W-1:0] FRAC_ONE = {1'b1, {FRACTION_BITS{1'b0}}};

   // breakpoints 4/11, 8/11, 10/11 compared against 11*t
   localparam logic [T11_W-1:0] BREAK_1 = T11_W'(4) << FRACTION_BITS;
   localparam logic [T11_W-1:0] BREAK_2 = T11_W'(8) << FRACTION_BITS;
   localparam logic [T11_W-1:0] BREAK_3 = T11_W'(10) << FRACTION_BITS;

   // segment centers in units of 1/22, offsets in 64ths
   localparam logic [DS_W-1:0] CENTER_2 = DS_W'(12) << FRACTION_BITS;
   localparam logic [DS_W-1:0] CENTER_3 = DS_W'(18) << FRACTION_BITS;
   localparam logic [DS_W-1:0] CENTER_4 = DS_W'(21) << FRACTION_BITS;
   localparam logic [5:0]      OFFSET_2 = 6'd48;
   localparam logic [5:0]      OFFSET_3 = 6'd60;
   localparam logic [5:0]      OFFSET_4 = 6'd63;

   localparam logic [D_W-1:0]   D_LIMIT     = D_W'(8) << FRACTION_BITS;
   localparam logic [NUM_W-1:0] CURVE_ROUND = NUM_W'(1) << (FRACTION_BITS + 5);
   localparam logic [PROD_W-1:0] BLEND_ROUND = PROD_W'(1) << (FRACTION_BITS - 1);

   // configuration registers
   logic signed [VALUE_BITS-1:0] start_ff;
   logic signed [VALUE_BITS-1:0] target_ff;
   logic [TIME_BITS-1:0]         length_ff;
   logic                         mode_ff;
   logic [VALUE_BITS:0]          delta_in;
   logic [VALUE_BITS-1:0]        delta_mag_ff;
   logic [VALUE_BITS-1:0]        delta_mag_in;
   logic                         delta_neg_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         target_ff <= '0;
         length_ff <= TIME_BITS'(1);
         mode_ff   <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_VALUE:  start_ff  <= csr_data[VALUE_BITS-1:0];
            CSR_TARGET_VALUE: target_ff <= csr_data[VALUE_BITS-1:0];
            CSR_ANIM_LENGTH:  length_ff <= csr_data[TIME_BITS-1:0];
            CSR_EASE_IN_MODE: mode_ff   <= csr_data[0];
         endcase
      end
   end

   // span magnitude and direction, refreshed every cycle from the registers
   assign delta_in     = {target_ff[VALUE_BITS-1], target_ff}
                       - {start_ff[VALUE_BITS-1], start_ff};
   assign delta_mag_in = delta_in[VALUE_BITS] ? VALUE_BITS'(-delta_in)
                                              : delta_in[VALUE_BITS-1:0];

   always_ff @(posedge clock) begin
      delta_mag_ff <= delta_mag_in;
      delta_neg_ff <= delta_in[VALUE_BITS];
   end

   // divider
   stage_ctl_type            div_ctl;
   logic [FRACTION_BITS-1:0] div_quotient;
   logic                     div_in_ready;
   logic [PIPE_STAGES:0]     move;

   bec_divider #(
      .TIME_BITS     (TIME_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_divider (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_ready     (div_in_ready),
      .in_elapsed   (req_elapsed_time),
      .divisor      (length_ff),
      .out_ctl      (div_ctl),
      .out_ready    (move[0]),
      .out_quotient (div_quotient)
   );

   assign req_stall = !div_in_ready;

   // control for the curve and blend stages
   stage_ctl_type ctl_ff [PIPE_STAGES];

   assign move[PIPE_STAGES] = !rsp_stall;
   for (genvar s = 0; s < PIPE_STAGES; s++) begin : g_move
      assign move[s] = !ctl_ff[s].valid || move[s+1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_STAGES; i++) begin
            ctl_ff[i] <= '0;
         end
      end else begin
         if (move[0]) begin
            ctl_ff[0] <= div_ctl;
         end
         for (int i = 1; i < PIPE_STAGES; i++) begin
            if (move[i]) begin
               ctl_ff[i] <= ctl_ff[i-1];
            end
         end
      end
   end

   // stage 0: pick segment, distance from its center
   logic [ONE_W-1:0]       frac_t;
   logic [ONE_W-1:0]       curve_t;
   logic [T11_W-1:0]       t11;
   logic [DS_W-1:0]        seg_center;
   logic [5:0]             seg_offset;
   logic signed [DS_W-1:0] seg_dist;
   logic [DS_W-1:0]        dist_abs;
   logic [D_W-1:0]         d_ff;
   logic [5:0]             offset_a_ff;

   assign frac_t  = div_ctl.done ? FRAC_ONE : {1'b0, div_quotient};
   assign curve_t = mode_ff ? FRAC_ONE - frac_t : frac_t;
   assign t11     = (T11_W'(curve_t) << 3) + (T11_W'(curve_t) << 1) + T11_W'(curve_t);

   always_comb begin
      if (t11 < BREAK_1) begin
         seg_center = '0;
         seg_offset = '0;
      end else if (t11 < BREAK_2) begin
         seg_center = CENTER_2;
         seg_offset = OFFSET_2;
      end else if (t11 < BREAK_3) begin
         seg_center = CENTER_3;
         seg_offset = OFFSET_3;
      end else begin
         seg_center = CENTER_4;
         seg_offset = OFFSET_4;
      end
   end

   assign seg_dist = signed'({1'b0, t11, 1'b0}) - signed'(seg_center);
   assign dist_abs = seg_dist[DS_W-1] ? DS_W'(-seg_dist) : DS_W'(seg_dist);

   always_ff @(posedge clock) begin
      if (move[0]) begin
         d_ff        <= dist_abs[D_W-1:0];
         offset_a_ff <= seg_offset;
      end
   end

   // stage 1: square
   logic [SQ_W-1:0] sq_ff;
   logic [5:0]      offset_b_ff;

   always_ff @(posedge clock) begin
      if (move[1]) begin
         sq_ff       <= d_ff * d_ff;
         offset_b_ff <= offset_a_ff;
      end
   end

   // stage 2: add offset, round to the fraction, mirror for ease-in
   logic [NUM_W-1:0] curve_num;
   logic [ONE_W-1:0] bounce;
   logic [ONE_W-1:0] f_ff;

   assign curve_num = NUM_W'(sq_ff) + (NUM_W'(offset_b_ff) << (2 * FRACTION_BITS))
                    + CURVE_ROUND;
   assign bounce    = curve_num[FRACTION_BITS+6 +: ONE_W];

   always_ff @(posedge clock) begin
      if (move[2]) begin
         f_ff <= mode_ff ? FRAC_ONE - bounce : bounce;
      end
   end

   // stage 3: scale the span
   logic [PROD_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      if (move[3]) begin
         prod_ff <= PROD_W'(delta_mag_ff) * PROD_W'(f_ff);
      end
   end

   // stage 4: round and blend into the output register
   logic [PROD_W-1:0]     prod_round;
   logic [VALUE_BITS-1:0] step;
   logic [VALUE_BITS:0]   blend;
   logic [VALUE_BITS-1:0] eased_ff;

   assign prod_round = prod_ff + BLEND_ROUND;
   assign step       = prod_round[FRACTION_BITS +: VALUE_BITS];
   assign blend      = delta_neg_ff
                     ? {start_ff[VALUE_BITS-1], start_ff} - {1'b0, step}
                     : {start_ff[VALUE_BITS-1], start_ff} + {1'b0, step};

   always_ff @(posedge clock) begin
      if (move[4]) begin
         eased_ff <= blend[VALUE_BITS-1:0];
      end
   end

   assign rsp_valid       = ctl_ff[PIPE_STAGES-1].valid;
   assign rsp_at_end      = ctl_ff[PIPE_STAGES-1].done;
   assign rsp_eased_value = eased_ff;

   `BEC_ASSERT_NEVER(a_no_stall_when_empty, clock, reset, !rsp_valid && req_stall,
      "request stalled with no result waiting")
   `BEC_ASSERT(a_distance_in_range, clock, reset, ctl_ff[0].valid |-> d_ff < D_LIMIT,
      "segment distance out of range")
   `BEC_ASSERT(a_curve_at_most_one, clock, reset, ctl_ff[2].valid |-> f_ff <= FRAC_ONE,
      "curve value above one")

endmodule

// File: tb/tb_bounce_easing_curve_core.sv
// self-checking testbench for the bounce easing curve core
module tb_bounce_easing_curve_core;
   import bec_pkg::*;

   localparam int VALUE_BITS = VALUE_BITS_DEFAULT;
   localparam int TIME_BITS = TIME_BITS_DEFAULT;
   localparam int FRAC = FRACTION_BITS_DEFAULT;
   localparam longint unsigned ONE = 64'd1 << FRAC;
   localparam int DRAIN_CYCLES = FRAC + 20;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic signed [VALUE_BITS-1:0] eased_value;
      logic                         at_end;
   } easing_result_type;

   logic                         clock;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [TIME_BITS-1:0]         req_elapsed_time = '0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic signed [VALUE_BITS-1:0] rsp_eased_value;
   logic                         rsp_at_end;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   csr_index_type                csr_index = CSR_START_VALUE;
   logic [VALUE_BITS-1:0]        csr_data = '0;

   // animation settings as last written to the block
   logic signed [VALUE_BITS-1:0] cfg_start = '0;
   logic signed [VALUE_BITS-1:0] cfg_target = '0;
   logic [TIME_BITS-1:0]         cfg_length = TIME_BITS'(1);
   logic                         cfg_ease_in = 1'b0;

   logic [TIME_BITS-1:0] pending_times[$];
   easing_result_type    expected_results[$];
   int                   queued_count = 0;
   int                   accepted_count = 0;
   int                   error_count = 0;
   int                   send_wait = 0;
   int                   stall_wait = 0;
   bit                   send_calm = 1'b0;
   bit                   recv_calm = 1'b0;
   logic                 hold_off = 1'b0;

   bounce_easing_curve_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_elapsed_time (req_elapsed_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_eased_value  (rsp_eased_value),
      .rsp_at_end       (rsp_at_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ease-out bounce on a q1.16 fraction, exact square then round half up
   function automatic longint unsigned bounce_curve(input longint unsigned t);
      longint unsigned seg_c, seg_k, dist_mag, num;
      longint signed   span;
      if (11 * t < 4 * ONE) begin
         seg_c = 0;
         seg_k = 0;
      end else if (11 * t < 8 * ONE) begin
         seg_c = 12;
         seg_k = 48;
      end else if (11 * t < 10 * ONE) begin
         seg_c = 18;
         seg_k = 60;
      end else begin
         seg_c = 21;
         seg_k = 63;
      end
      span = longint'(22 * t) - longint'(seg_c * ONE);
      dist_mag = (span < 0) ? -span : span;
      num = dist_mag * dist_mag + ((seg_k * ONE) << FRAC);
      return (num + (64'd1 << (FRAC + 5))) >> (FRAC + 6);
   endfunction

   function automatic easing_result_type predict_easing(input logic [TIME_BITS-1:0] elapsed);
      easing_result_type res;
      longint unsigned   frac, curve, mag, prod;
      longint signed     delta, blend;
      res.at_end = (elapsed >= cfg_length);
      // zero duration counts as already finished, no divide
      if (res.at_end || cfg_length == 0)
         frac = ONE;
      else
         frac = (64'(elapsed) << FRAC) / 64'(cfg_length);
      if (cfg_ease_in)
         curve = ONE - bounce_curve(ONE - frac);
      else
         curve = bounce_curve(frac);
      delta = longint'(cfg_target) - longint'(cfg_start);
      mag = (delta < 0) ? -delta : delta;
      prod = (mag * curve + (ONE >> 1)) >> FRAC;
      blend = (delta < 0) ? longint'(cfg_start) - longint'(prod)
                          : longint'(cfg_start) + longint'(prod);
      res.eased_value = blend[VALUE_BITS-1:0];
      return res;
   endfunction

   // sender: one request per transfer, random gap after each
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         send_wait = 0;
      end else begin
         offer = req_valid;
         if (req_valid && !req_stall) begin
            expected_results.push_back(predict_easing(req_elapsed_time));
            accepted_count++;
            offer = 1'b0;
         end
         if (!offer) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (pending_times.size() > 0) begin
               req_elapsed_time <= pending_times.pop_front();
               offer = 1'b1;
               if ($urandom_range(0, 39) == 0)
                  send_calm = !send_calm;
               send_wait = send_calm ? 0 : $urandom_range(0, 16);
            end
         end
         req_valid <= offer;
      end
   end

   // receiver: check each result transfer, then stall for a random while
   always @(posedge clock) begin
      easing_result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_wait = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result eased_value %0d at_end %0b",
                      rsp_eased_value, rsp_at_end);
               error_count++;
            end else begin
               want = expected_results.pop_front();
               if (rsp_eased_value !== want.eased_value) begin
                  $error("eased_value expected %0d actual %0d",
                         want.eased_value, rsp_eased_value);
                  error_count++;
               end
               if (rsp_at_end !== want.at_end) begin
                  $error("at_end expected %0b actual %0b", want.at_end, rsp_at_end);
                  error_count++;
               end
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm = !recv_calm;
            stall_wait = recv_calm ? 0 : $urandom_range(0, 16);
         end else if (stall_wait > 0) begin
            stall_wait--;
         end
         rsp_stall <= hold_off || (stall_wait > 0);
      end
   end

   // long receiver hold-off while requests keep coming, fills the pipeline
   initial begin
      do @(posedge clock);
      while (!(accepted_count >= 370 && pending_times.size() > 60));
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   task automatic write_reg(input csr_index_type idx, input logic [VALUE_BITS-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_START_VALUE:  cfg_start = data;
         CSR_TARGET_VALUE: cfg_target = data;
         CSR_ANIM_LENGTH:  cfg_length = data[TIME_BITS-1:0];
         CSR_EASE_IN_MODE: cfg_ease_in = data[0];
         default: ;
      endcase
   endtask

   task automatic setup_anim(input logic [VALUE_BITS-1:0] start_v,
                             input logic [VALUE_BITS-1:0] target_v,
                             input logic [TIME_BITS-1:0] length_v,
                             input logic mode_v);
      write_reg(CSR_START_VALUE, start_v);
      write_reg(CSR_TARGET_VALUE, target_v);
      write_reg(CSR_ANIM_LENGTH, length_v);
      write_reg(CSR_EASE_IN_MODE, {{(VALUE_BITS-1){1'b0}}, mode_v});
   endtask

   task automatic queue_time(input logic [TIME_BITS-1:0] t);
      pending_times.push_back(t);
      queued_count++;
   endtask

   // wait until every queued request has come back
   task automatic settle();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_results.size() != 0);
   endtask

   function automatic logic [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return VALUE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [TIME_BITS-1:0] pick_length();
      case ($urandom_range(0, 7))
         0: return 16'd1;
         1: return 16'hffff;
         2: return TIME_BITS'($urandom_range(0, 3));
         3, 4: return TIME_BITS'($urandom_range(1, 64));
         default: return TIME_BITS'($urandom_range(1, 65535));
      endcase
   endfunction

   initial begin
      logic [TIME_BITS-1:0] len;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // full swing, shortest nonzero duration
      setup_anim(16'h8000, 16'h7fff, 16'd1, 1'b0);
      queue_time(16'd0);
      queue_time(16'd1);
      queue_time(16'hffff);
      settle();

      // reverse swing, longest duration, ease-in, at times near 4/11, 8/11 and 10/11
      setup_anim(16'h7fff, 16'h8000, 16'hffff, 1'b1);
      queue_time(16'd0);
      queue_time(16'd23831);
      queue_time(16'd47662);
      queue_time(16'd59577);
      queue_time(16'hfffe);
      queue_time(16'hffff);
      settle();

      // duration 11 puts the breakpoints on whole ticks
      setup_anim(16'd100, -16'sd100, 16'd11, 1'b0);
      queue_time(16'd3);
      queue_time(16'd4);
      queue_time(16'd7);
      queue_time(16'd8);
      queue_time(16'd9);
      queue_time(16'd10);
      settle();
      write_reg(CSR_EASE_IN_MODE, 16'd1);
      queue_time(16'd1);
      queue_time(16'd3);
      queue_time(16'd7);
      settle();

      // zero duration is always past the end
      setup_anim(16'd5, -16'sd7, 16'd0, 1'b1);
      queue_time(16'd0);
      queue_time(16'hffff);
      settle();

      // no movement at all
      setup_anim(16'd1234, 16'd1234, 16'd1000, 1'b0);
      queue_time(16'd500);
      settle();

      for (int p = 0; p < 8; p++) begin
         len = pick_length();
         setup_anim(pick_value(), pick_value(), len, 1'($urandom_range(0, 1)));
         for (int i = 0; i < 110; i++) begin
            // mostly inside the animation, some anywhere
            if ($urandom_range(0, 3) == 0 || len == 0)
               queue_time(TIME_BITS'($urandom));
            else
               queue_time(TIME_BITS'($urandom_range(0, len)));
         end
         settle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("tb_bounce_easing_curve_core: done, clean");
      else
         $display("tb_bounce_easing_curve_core: done, errors");
      $finish;
   end

   initial begin
      #1600000;
      $display("tb_bounce_easing_curve_core: done, errors");
      $finish;
   end

endmodule
